### rtl/ffa_pkg.sv
// Shared types and codes for the first-fit free-list allocator.
package ffa_pkg;

    // Request command codes
    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_ADD   = 2'd2
    } t_cmd;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_ROV,
        S_AL_CHK,
        S_AL_QRD,
        S_AL_QWR,
        S_AD_RD,
        S_AD_WR,
        S_LK_GO,
        S_LK_WALK,
        S_LK_HB,
        S_LK_NX,
        S_LK_P,
        S_FIN
    } t_state;

    localparam int CMD_W    = 2;
    localparam int BYTES_W  = 16;
    localparam int ADDR_W   = 12;
    localparam int STATUS_W = 2;
    // Width of the rounded byte count before scaling to units
    localparam int DIV_W    = 17;
    // Bytes per heap unit, a power of two, and its shift
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

endpackage

### rtl/ffa_if.sv
// Request and response channel interfaces of the allocator.
interface ffa_req_if import ffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [BYTES_W-1:0]   req_bytes;
    logic [ADDR_W-1:0]    block_addr;

    modport source (output valid, cmd, req_bytes, block_addr, input ready);
    modport sink   (input valid, cmd, req_bytes, block_addr, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    alloc_addr;

    modport source (output valid, status, alloc_addr, input ready);
    modport sink   (input valid, status, alloc_addr, output ready);
endinterface

### rtl/ffa_hdr_store.sv
// Header store: one next index and one size per heap unit, registered read.
module ffa_hdr_store import ffa_pkg::*; #(
    parameter int HEAP_UNITS = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(HEAP_UNITS)-1:0] i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(HEAP_UNITS)-1:0] i_wr_addr,
    input  logic [$clog2(HEAP_UNITS)-1:0] i_wr_next,
    input  logic [$clog2(HEAP_UNITS):0]   i_wr_size,
    output logic [$clog2(HEAP_UNITS)-1:0] o_rd_next,
    output logic [$clog2(HEAP_UNITS):0]   o_rd_size
);
    localparam int AW = $clog2(HEAP_UNITS);
    localparam int SW = AW + 1;

    logic [AW+SW-1:0] r_mem [HEAP_UNITS];
    logic [AW+SW-1:0] r_mem_q;
    logic             r_rd_base;
    logic [AW-1:0]    r_base_next;

    // Base sentinel: size is always zero, only its link changes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_next <= '0;
        end else if (i_wr_en && i_wr_addr == '0) begin
            r_base_next <= i_wr_next;
        end
    end

    // Write all other headers into the array
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr != '0) begin
            r_mem[i_wr_addr] <= {i_wr_next, i_wr_size};
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_mem_q   <= r_mem[i_rd_addr];
        r_rd_base <= (i_rd_addr == '0);
    end

    assign o_rd_next = r_rd_base ? r_base_next : r_mem_q[AW+SW-1:SW];
    assign o_rd_size = r_rd_base ? '0 : r_mem_q[SW-1:0];
endmodule

### rtl/first_fit_free_list_allocator.sv
// Top level: first-fit free-list heap allocator with coalescing.
//
//  Channel   Direction  Payload
//  i_req     in         cmd, req_bytes, block_addr
//  o_rsp     out        status, alloc_addr
//
// One request at a time; the free-list walk reads one header per cycle from
// the header store, which has one read and one write port. An allocate
// checks headers until it splits a block, takes an exact fit or reports
// no_space; a free makes one insertion and add region makes two. Reset is
// synchronous and clears the base sentinel link and the rover; no clearing
// pass. A waiting response holds its register and the sequencer parks until
// it is taken.
module first_fit_free_list_allocator import ffa_pkg::*; #(
    parameter int HEAP_UNITS = 4096,
    parameter int PAGE_UNITS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffa_req_if.sink     i_req,
    ffa_rsp_if.source   o_rsp
);
    localparam int AW  = $clog2(HEAP_UNITS);
    localparam int SW  = AW + 1;
    localparam int STW = $clog2(HEAP_UNITS + 4);
    localparam int CW  = ((SW > DIV_W) ? SW : DIV_W) + 1;
    localparam logic [STW-1:0] WALK_LIMIT = STW'(HEAP_UNITS + 2);
    localparam logic [SW:0]    HEAP_S     = (SW+1)'(HEAP_UNITS);
    localparam logic [SW-1:0]  PAGE_SZ    = SW'(PAGE_UNITS - 1);

    t_state           r_state, n_state;
    logic             r_ovalid, n_ovalid;
    logic [AW-1:0]    r_rover, n_rover;
    t_status          r_ostatus, n_ostatus;
    logic [ADDR_W-1:0] r_oaddr, n_oaddr;
    t_status          r_status, n_status;
    logic [ADDR_W-1:0] r_res, n_res;
    logic             r_is_add, n_is_add;
    logic             r_phase, n_phase;
    logic [DIV_W-1:0] r_need, n_need;
    logic [AW-1:0]    r_prev, n_prev;
    logic [SW-1:0]    r_prev_size, n_prev_size;
    logic [AW-1:0]    r_p, n_p;
    logic [SW-1:0]    r_p_size, n_p_size;
    logic [STW-1:0]   r_steps, n_steps;
    logic [AW-1:0]    r_hb, n_hb;
    logic [SW-1:0]    r_hb_size, n_hb_size;
    logic [AW-1:0]    r_hbn_next, n_hbn_next;
    logic [SW-1:0]    r_hbn_size, n_hbn_size;
    logic [AW-1:0]    r_nx, n_nx;
    logic [AW-1:0]    r_q, n_q;

    logic [AW-1:0]    m_rd_addr;
    logic             m_wr_en;
    logic [AW-1:0]    m_wr_addr;
    logic [AW-1:0]    m_wr_next;
    logic [SW-1:0]    m_wr_size;
    logic [AW-1:0]    m_rd_next;
    logic [SW-1:0]    m_rd_size;

    logic             accept;
    logic [SW:0]      sum_a, sum_b, wrap_q, inc_p;
    logic [SW-1:0]    new_size;
    logic [AW-1:0]    hbn_next;
    logic [SW-1:0]    hbn_size;

    ffa_hdr_store #(.HEAP_UNITS(HEAP_UNITS)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (m_rd_addr),
        .i_wr_en   (m_wr_en),
        .i_wr_addr (m_wr_addr),
        .i_wr_next (m_wr_next),
        .i_wr_size (m_wr_size),
        .o_rd_next (m_rd_next),
        .o_rd_size (m_rd_size)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign accept           = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_ostatus;
    assign o_rsp.alloc_addr = r_oaddr;

    // Split arithmetic: tail index of the shrunk block, wrapped to the heap
    assign new_size = m_rd_size - SW'(r_need);
    assign sum_a    = (SW+1)'(r_p) + (SW+1)'(new_size);
    assign wrap_q   = (sum_a >= HEAP_S) ? sum_a - HEAP_S : sum_a;
    assign inc_p    = ((SW+1)'(r_q) + 1'b1 >= HEAP_S) ? '0 : (SW+1)'(r_q) + 1'b1;

    // Merge of the inserted block with its successor
    assign sum_b = (SW+1)'(r_hb_size) + (SW+1)'(m_rd_size);
    always_comb begin
        if ((SW+1)'(r_hb) + (SW+1)'(r_hb_size) == (SW+1)'(r_nx) && m_rd_size != '0) begin
            hbn_size = (sum_b > HEAP_S) ? HEAP_S[SW-1:0] : sum_b[SW-1:0];
            hbn_next = m_rd_next;
        end else begin
            hbn_size = r_hb_size;
            hbn_next = r_nx;
        end
    end

    // Sequencer: next state, header store access and datapath updates
    always_comb begin
        logic [SW:0] sum_p;
        logic [CW-1:0] req_w;

        n_state     = r_state;
        n_ovalid    = r_ovalid;
        n_rover     = r_rover;
        n_ostatus   = r_ostatus;
        n_oaddr     = r_oaddr;
        n_status    = r_status;
        n_res       = r_res;
        n_is_add    = r_is_add;
        n_phase     = r_phase;
        n_need      = r_need;
        n_prev      = r_prev;
        n_prev_size = r_prev_size;
        n_p         = r_p;
        n_p_size    = r_p_size;
        n_steps     = r_steps;
        n_hb        = r_hb;
        n_hb_size   = r_hb_size;
        n_hbn_next  = r_hbn_next;
        n_hbn_size  = r_hbn_size;
        n_nx        = r_nx;
        n_q         = r_q;
        m_rd_addr   = r_p;
        m_wr_en     = 1'b0;
        m_wr_addr   = r_p;
        m_wr_next   = r_nx;
        m_wr_size   = r_p_size;
        sum_p       = (SW+1)'(r_p_size) + (SW+1)'(r_hbn_size);
        req_w       = '0;

        // Drop the response once taken
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res    = '0;
                    n_status = ST_BAD;
                    n_phase  = 1'b0;
                    n_is_add = 1'b0;
                    n_state  = S_FIN;
                    unique case (t_cmd'(i_req.cmd))
                        CMD_ALLOC: begin
                            // Round bytes up to units, add the header unit
                            if (i_req.req_bytes != '0) begin
                                n_need    = ((DIV_W'(i_req.req_bytes) +
                                              DIV_W'(UNIT_BYTES - 1)) >> UNIT_SHIFT) +
                                            DIV_W'(1);
                                m_rd_addr = r_rover;
                                n_state   = S_AL_ROV;
                            end
                        end
                        CMD_FREE: begin
                            if (i_req.block_addr >= ADDR_W'(2) &&
                                (DIV_W+1)'(i_req.block_addr) < (DIV_W+1)'(HEAP_UNITS)) begin
                                n_hb    = AW'(i_req.block_addr - 1'b1);
                                n_state = S_LK_GO;
                            end
                        end
                        CMD_ADD: begin
                            if (i_req.block_addr != '0 &&
                                (DIV_W+1)'(i_req.block_addr) + (DIV_W+1)'(PAGE_UNITS) <=
                                (DIV_W+1)'(HEAP_UNITS)) begin
                                n_hb     = AW'(i_req.block_addr);
                                n_is_add = 1'b1;
                                n_state  = S_AD_RD;
                            end
                        end
                        default: begin
                            n_status = ST_BAD;
                        end
                    endcase
                end
            end

            // Start the search after the rover
            S_AL_ROV: begin
                n_prev      = r_rover;
                n_prev_size = m_rd_size;
                n_p         = m_rd_next;
                m_rd_addr   = m_rd_next;
                n_steps     = '0;
                n_state     = S_AL_CHK;
            end

            // First-fit check, one header a cycle
            S_AL_CHK: begin
                req_w = CW'(r_need);
                if (CW'(m_rd_size) >= req_w) begin
                    n_rover = r_prev;
                    if (CW'(m_rd_size) == req_w) begin
                        m_wr_en   = 1'b1;
                        m_wr_addr = r_prev;
                        m_wr_next = m_rd_next;
                        m_wr_size = r_prev_size;
                        n_q       = r_p;
                        n_state   = S_AL_QWR;
                    end else begin
                        m_wr_en   = 1'b1;
                        m_wr_addr = r_p;
                        m_wr_next = m_rd_next;
                        m_wr_size = new_size;
                        n_q       = AW'(wrap_q);
                        n_state   = S_AL_QRD;
                    end
                end else if (r_p == r_rover || r_steps >= WALK_LIMIT) begin
                    n_status = ST_NOSPACE;
                    n_state  = S_FIN;
                end else begin
                    n_prev      = r_p;
                    n_prev_size = m_rd_size;
                    n_p         = m_rd_next;
                    m_rd_addr   = m_rd_next;
                    n_steps     = r_steps + 1'b1;
                end
            end

            // Read the tail header before stamping its size
            S_AL_QRD: begin
                m_rd_addr = r_q;
                n_state   = S_AL_QWR;
            end

            // Stamp the tail size and finish; an exact fit rewrites its header as is
            S_AL_QWR: begin
                n_res     = ADDR_W'(inc_p[SW-1:0]);
                n_status  = ST_OK;
                n_state   = S_FIN;
                m_wr_en   = 1'b1;
                m_wr_addr = r_q;
                m_wr_next = m_rd_next;
                m_wr_size = SW'(r_need);
            end

            // Add region: read the header about to get a new size
            S_AD_RD: begin
                m_rd_addr = r_hb;
                n_state   = S_AD_WR;
            end

            S_AD_WR: begin
                m_wr_en   = 1'b1;
                m_wr_addr = r_hb;
                m_wr_next = m_rd_next;
                m_wr_size = r_phase ? PAGE_SZ : '0;
                n_state   = S_LK_GO;
            end

            // Insert: start the address-ordered walk at the rover
            S_LK_GO: begin
                m_rd_addr = r_rover;
                n_p       = r_rover;
                n_steps   = '0;
                n_state   = S_LK_WALK;
            end

            S_LK_WALK: begin
                if ((r_hb > r_p && r_hb < m_rd_next) ||
                    (r_p >= m_rd_next && (r_hb > r_p || r_hb < m_rd_next))) begin
                    n_nx      = m_rd_next;
                    n_p_size  = m_rd_size;
                    m_rd_addr = r_hb;
                    n_state   = S_LK_HB;
                end else if (r_steps >= WALK_LIMIT) begin
                    n_status = ST_BAD;
                    n_state  = S_FIN;
                end else begin
                    n_steps   = r_steps + 1'b1;
                    n_p       = m_rd_next;
                    m_rd_addr = m_rd_next;
                end
            end

            S_LK_HB: begin
                n_hb_size = m_rd_size;
                m_rd_addr = r_nx;
                n_state   = S_LK_NX;
            end

            // Merge with the successor
            S_LK_NX: begin
                m_wr_en    = 1'b1;
                m_wr_addr  = r_hb;
                m_wr_next  = hbn_next;
                m_wr_size  = hbn_size;
                n_hbn_next = hbn_next;
                n_hbn_size = hbn_size;
                n_state    = S_LK_P;
            end

            // Merge with the predecessor and move the rover
            S_LK_P: begin
                m_wr_en   = 1'b1;
                m_wr_addr = r_p;
                if ((SW+1)'(r_p) + (SW+1)'(r_p_size) == (SW+1)'(r_hb) && r_hbn_size != '0) begin
                    m_wr_size = (sum_p > HEAP_S) ? HEAP_S[SW-1:0] : sum_p[SW-1:0];
                    m_wr_next = r_hbn_next;
                end else begin
                    m_wr_size = r_p_size;
                    m_wr_next = r_hb;
                end
                n_rover = r_p;
                if (r_is_add && !r_phase) begin
                    n_phase = 1'b1;
                    n_hb    = r_hb + 1'b1;
                    n_state = S_AD_RD;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_FIN;
                end
            end

            // Hand the result to the output register
            S_FIN: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_oaddr   = (r_status == ST_OK) ? r_res : '0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_rover  <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_rover  <= n_rover;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ostatus   <= n_ostatus;
        r_oaddr     <= n_oaddr;
        r_status    <= n_status;
        r_res       <= n_res;
        r_is_add    <= n_is_add;
        r_phase     <= n_phase;
        r_need      <= n_need;
        r_prev      <= n_prev;
        r_prev_size <= n_prev_size;
        r_p         <= n_p;
        r_p_size    <= n_p_size;
        r_steps     <= n_steps;
        r_hb        <= n_hb;
        r_hb_size   <= n_hb_size;
        r_hbn_next  <= n_hbn_next;
        r_hbn_size  <= n_hbn_size;
        r_nx        <= n_nx;
        r_q         <= n_q;
    end
endmodule

### tb/first_fit_free_list_allocator_test.sv
// Self-checking testbench for the first-fit free-list heap allocator.
module first_fit_free_list_allocator_test import ffa_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP  = 4096;
    localparam int UNITB = 16;
    localparam int PAGE  = 256;
    localparam int WALK_MAX = HEAP + 2;
    localparam int N_RANDOM = 800;
    localparam int CALM_AFTER = 680;

    typedef struct packed {
        t_status          status;
        logic [ADDR_W-1:0] addr;
    } t_reply;

    // Heap shadow and queue of replies still owed by the allocator
    class heap_scoreboard;
        int unsigned link_of[HEAP];
        int unsigned units_of[HEAP];
        int unsigned rover;
        t_reply      owed[$];
        int          errors;
        int          checked;
        int          n_ok, n_nospace, n_bad;

        function new();
            foreach (link_of[i]) begin
                link_of[i]  = 0;
                units_of[i] = 0;
            end
            rover = 0;
        endfunction

        function int unsigned clamp_sum(int unsigned a, int unsigned b);
            return (a + b > HEAP) ? HEAP : a + b;
        endfunction

        // Insert header hb in address order and merge with neighbors
        function bit insert_block(int unsigned hb);
            int unsigned p;
            int unsigned nx;
            int unsigned steps;
            p = rover;
            steps = 0;
            forever begin
                nx = link_of[p];
                if (hb > p && hb < nx) break;
                if (p >= nx && (hb > p || hb < nx)) break;
                steps++;
                if (steps > WALK_MAX) return 0;
                p = nx;
            end
            nx = link_of[p];
            if (hb + units_of[hb] == nx && units_of[nx] > 0) begin
                units_of[hb] = clamp_sum(units_of[hb], units_of[nx]);
                link_of[hb]  = link_of[nx];
            end else begin
                link_of[hb] = nx;
            end
            if (p + units_of[p] == hb && units_of[hb] > 0) begin
                units_of[p] = clamp_sum(units_of[p], units_of[hb]);
                link_of[p]  = link_of[hb];
            end else begin
                link_of[p] = hb;
            end
            rover = p;
            return 1;
        endfunction

        function t_reply carve(int unsigned bytes);
            t_reply r;
            int unsigned need, prev, p, steps;
            r = '{ST_NOSPACE, '0};
            if (bytes == 0) begin
                r.status = ST_BAD;
                return r;
            end
            need = (bytes + UNITB - 1) / UNITB + 1;
            prev = rover;
            p = link_of[prev];
            steps = 0;
            forever begin
                if (units_of[p] >= need) break;
                if (p == rover) return r;
                steps++;
                if (steps > WALK_MAX) return r;
                prev = p;
                p = link_of[p];
            end
            if (units_of[p] == need) begin
                link_of[prev] = link_of[p];
            end else begin
                units_of[p] -= need;
                p = (p + units_of[p]) % HEAP;
                units_of[p] = need;
            end
            rover = prev;
            r.status = ST_OK;
            r.addr = ADDR_W'((p + 1) % HEAP);
            return r;
        endfunction

        function t_reply add_page(int unsigned start);
            t_reply r;
            r = '{ST_BAD, '0};
            if (start == 0 || start + PAGE > HEAP) return r;
            units_of[start] = 0;
            if (!insert_block(start)) return r;
            units_of[start + 1] = PAGE - 1;
            if (!insert_block(start + 1)) return r;
            r.status = ST_OK;
            return r;
        endfunction

        // Note an accepted request; returns the reply it must produce
        function t_reply note_request(logic [1:0] cmd, logic [15:0] bytes,
                                      logic [11:0] addr);
            t_reply r;
            r = '{ST_BAD, '0};
            case (cmd)
                CMD_ALLOC: r = carve(bytes);
                CMD_FREE: begin
                    if (addr >= 2) begin
                        if (insert_block(addr - 1)) r.status = ST_OK;
                    end
                end
                CMD_ADD: r = add_page(addr);
                default: r = '{ST_BAD, '0};
            endcase
            if (r.status != ST_OK) r.addr = '0;
            owed.push_back(r);
            return r;
        endfunction

        task mismatch(string msg);
            errors++;
            $display("%0t ERROR %s", $realtime, msg);
        endtask

        task check_reply(logic [1:0] status, logic [11:0] addr);
            t_reply e;
            if (owed.size() == 0) begin
                mismatch($sformatf("unexpected reply status=%0d addr=%0d", status, addr));
                return;
            end
            e = owed.pop_front();
            checked++;
            case (e.status)
                ST_OK:      n_ok++;
                ST_NOSPACE: n_nospace++;
                default:    n_bad++;
            endcase
            if (status !== e.status)
                mismatch($sformatf("status got %0d want %0d", status, e.status));
            if (addr !== e.addr)
                mismatch($sformatf("alloc_addr got %0d want %0d", addr, e.addr));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    ffa_req_if req ();
    ffa_rsp_if rsp ();

    heap_scoreboard sb;
    logic [11:0] live_blocks[$];
    int          free_pages[$];
    bit          calm;

    first_fit_free_list_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    // Clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #200ms;
        $display("Timeout waiting for replies");
        $display("Test completed with failures");
        $finish;
    end

    // Send one request, hold until taken, then maybe idle a burst
    task send_request(logic [1:0] cmd, logic [15:0] bytes, logic [11:0] addr);
        t_reply r;
        int gap;
        req.valid      <= 1'b1;
        req.cmd        <= cmd;
        req.req_bytes  <= bytes;
        req.block_addr <= addr;
        do @(posedge i_clk); while (!req.ready);
        r = sb.note_request(cmd, bytes, addr);
        if (cmd == CMD_ALLOC && r.status == ST_OK) live_blocks.push_back(r.addr);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task free_live_block();
        int k;
        logic [11:0] a;
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        send_request(CMD_FREE, 16'($urandom), a);
    endtask

    task add_next_page();
        int k;
        int s;
        k = $urandom_range(0, free_pages.size() - 1);
        s = free_pages[k];
        free_pages.delete(k);
        send_request(CMD_ADD, 16'($urandom), 12'(s));
    endtask

    // Reply side: random stalls, check every accepted reply
    initial begin
        int stall;
        rsp.ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp.valid && rsp.ready) sb.check_reply(rsp.status, rsp.alloc_addr);
            if (stall > 0) begin
                stall--;
                rsp.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 7);
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Stimulus
    initial begin
        int sel;
        int wait_cnt;
        sb = new();
        calm = 0;
        req.valid = 1'b0;
        req.cmd = CMD_ALLOC;
        req.req_bytes = '0;
        req.block_addr = '0;
        for (int k = 1; k < HEAP / PAGE; k++) free_pages.push_back(k * PAGE);
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty heap, bad codes, edges of sizes and addresses
        send_request(CMD_ALLOC, 16'd1, 12'd0);
        send_request(CMD_ADD, 16'd0, 12'd0);
        send_request(CMD_ADD, 16'hFFFF, 12'd3841);
        send_request(CMD_ADD, 16'd0, 12'hFFF);
        send_request(CMD_ADD, 16'd0, 12'd256);
        free_pages.delete(0);
        send_request(CMD_ALLOC, 16'd0, 12'hFFF);
        send_request(CMD_ALLOC, 16'hFFFF, 12'd0);
        send_request(CMD_ALLOC, 16'd4080, 12'd0);
        send_request(2'd3, 16'hFFFF, 12'hFFF);
        send_request(CMD_FREE, 16'd0, 12'd0);
        send_request(CMD_FREE, 16'd0, 12'd1);
        send_request(CMD_ALLOC, 16'd1, 12'd0);
        send_request(CMD_ALLOC, 16'd16, 12'd0);
        send_request(CMD_ALLOC, 16'd17, 12'd0);
        send_request(CMD_ALLOC, 16'd3968, 12'd0);
        free_live_block();
        free_live_block();
        send_request(CMD_ADD, 16'd0, 12'd3840);
        free_pages.delete(free_pages.size() - 1);
        send_request(CMD_ALLOC, 16'd4064, 12'd0);
        free_live_block();
        free_live_block();

        // Random traffic: mostly well-formed alloc/free, some noise
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n >= CALM_AFTER) calm = 1;
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(CMD_ALLOC, 16'($urandom_range(1, 65535)), 12'($urandom));
                else
                    send_request(CMD_ALLOC, 16'($urandom_range(1, 400)), 12'($urandom));
            end else if (sel < 85 && live_blocks.size() > 0) begin
                free_live_block();
            end else if (sel < 90 && free_pages.size() > 0) begin
                add_next_page();
            end else begin
                case ($urandom_range(0, 4))
                    0: send_request(CMD_ALLOC, 16'd0, 12'($urandom));
                    1: send_request(CMD_FREE, 16'($urandom), 12'($urandom_range(0, 1)));
                    2: send_request(2'd3, 16'($urandom), 12'($urandom));
                    3: send_request(CMD_ADD, 16'($urandom), 12'($urandom_range(3841, 4095)));
                    default: send_request(CMD_ADD, 16'($urandom), 12'd0);
                endcase
            end
        end
        req.valid <= 1'b0;

        // Drain outstanding replies, then settle
        wait_cnt = 0;
        while (sb.owed.size() > 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (50) @(posedge i_clk);
        if (sb.owed.size() > 0) sb.mismatch($sformatf("%0d replies never came", sb.owed.size()));

        $display("Checked %0d replies: %0d ok, %0d no_space, %0d bad_request",
                 sb.checked, sb.n_ok, sb.n_nospace, sb.n_bad);
        $display("Traffic covered region adds, splits, exact fits and coalescing frees");
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_hdr_store.sv
rtl/first_fit_free_list_allocator.sv
tb/first_fit_free_list_allocator_test.sv
